FILE: hw/rtl/word_frame_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// word_frame_deframer_unit_assert
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef WORD_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WORD_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfd assertion failed");

// next-cycle implication, checked out of reset
`define WFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfd assertion failed");

`endif

FILE: hw/rtl/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// types and constants shared by the word frame deframer
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam int unsigned WordWidth            = 32;
    localparam int unsigned BytesPerWord         = 4;
    localparam int unsigned MaxPayloadBytesDflt  = 64;
    localparam int unsigned CfgIndexWidth        = 3;
    localparam int unsigned WordIndexWidth       = 4;
    localparam int unsigned DataSizeWidth        = 5;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CfgStartMarker     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgStateTypeMarker = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgDataTypeMarker  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgEndMarker       = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgSwapBytes       = 3'd4;

    typedef struct packed {
        logic [WordWidth-1:0] start_marker;
        logic [WordWidth-1:0] state_type_marker;
        logic [WordWidth-1:0] data_type_marker;
        logic [WordWidth-1:0] end_marker;
        logic                 swap_bytes;
    } t_cfg;

    typedef struct packed {
        logic                      frame_status;
        logic [WordWidth-1:0]      word_value;
        logic                      state_id_write;
        logic                      data_id_write;
        logic                      state_value_write;
        logic                      data_word_write;
        logic [WordIndexWidth-1:0] data_word_index;
        logic                      state_frame_complete;
        logic                      data_frame_complete;
        logic [DataSizeWidth-1:0]  data_size;
    } t_result;

endpackage

FILE: hw/rtl/wfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfd_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module wfd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wfd_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [wfd_pkg::WordWidth-1:0]       i_cfg_data,
    output wfd_pkg::t_cfg                       o_cfg
);
    import wfd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgStartMarker:     r_cfg.start_marker      <= i_cfg_data;
                CfgStateTypeMarker: r_cfg.state_type_marker <= i_cfg_data;
                CfgDataTypeMarker:  r_cfg.data_type_marker  <= i_cfg_data;
                CfgEndMarker:       r_cfg.end_marker        <= i_cfg_data;
                CfgSwapBytes:       r_cfg.swap_bytes        <= i_cfg_data[0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/wfd_parser.sv
// ----------------------------------------------------------------------------
// wfd_parser
// frame phase machine: decodes one word per step into a result
// ----------------------------------------------------------------------------
module wfd_parser #(
    parameter int unsigned MAX_PAYLOAD_BYTES = wfd_pkg::MaxPayloadBytesDflt
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [wfd_pkg::WordWidth-1:0]   i_word,
    input  wfd_pkg::t_cfg                   i_cfg,
    output wfd_pkg::t_result                o_result
);
    import wfd_pkg::*;

    localparam int unsigned MaxWords = MAX_PAYLOAD_BYTES / BytesPerWord;
    localparam int unsigned CntWidth = $clog2(MaxWords + 1);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_STATE_ID,
        PH_DATA_ID,
        PH_STATE_VAL,
        PH_DATA_LEN,
        PH_STATE_END,
        PH_PAYLOAD
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [CntWidth-1:0]   r_words, n_words;
    logic [CntWidth-1:0]   r_index, n_index;
    logic [WordWidth-1:0]  w;
    t_result               res;

    assign w = i_cfg.swap_bytes ? {i_word[7:0], i_word[15:8], i_word[23:16], i_word[31:24]}
                                : i_word;

    always_comb begin
        n_phase = r_phase;
        n_words = r_words;
        n_index = r_index;
        res            = '0;
        res.word_value = w;
        case (r_phase)
            PH_WAIT: begin
                if (w == i_cfg.start_marker) begin
                    n_phase = PH_TYPE;
                end else begin
                    res.frame_status = 1'b1;
                end
            end
            PH_TYPE: begin
                // state type wins when both markers match
                if (w == i_cfg.state_type_marker) begin
                    n_phase = PH_STATE_ID;
                end else if (w == i_cfg.data_type_marker) begin
                    n_phase = PH_DATA_ID;
                end else begin
                    n_phase          = PH_WAIT;
                    res.frame_status = 1'b1;
                end
            end
            PH_STATE_ID: begin
                res.state_id_write = 1'b1;
                n_phase            = PH_STATE_VAL;
            end
            PH_DATA_ID: begin
                res.data_id_write = 1'b1;
                n_phase           = PH_DATA_LEN;
            end
            PH_STATE_VAL: begin
                res.state_value_write = 1'b1;
                n_phase               = PH_STATE_END;
            end
            PH_STATE_END: begin
                res.state_frame_complete = (w == i_cfg.end_marker);
                res.frame_status         = 1'b1;
                n_phase                  = PH_WAIT;
            end
            PH_DATA_LEN: begin
                if (w > WordWidth'(MAX_PAYLOAD_BYTES)) begin
                    res.frame_status = 1'b1;
                    n_phase          = PH_WAIT;
                end else begin
                    // byte count to word count, remainder dropped
                    n_words = w[CntWidth+1:2];
                    n_index = '0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_index >= r_words) begin
                    res.data_frame_complete = (w == i_cfg.end_marker);
                    res.data_size           = (w == i_cfg.end_marker)
                                              ? DataSizeWidth'(r_words) : '0;
                    res.frame_status        = 1'b1;
                    n_phase                 = PH_WAIT;
                end else begin
                    res.data_word_write = 1'b1;
                    res.data_word_index = WordIndexWidth'(r_index);
                    n_index             = r_index + 1'b1;
                end
            end
            default: begin
                n_phase = PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_words <= '0;
            r_index <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_words <= n_words;
            r_index <= n_index;
        end
    end

    assign o_result = res;

endmodule

FILE: hw/rtl/word_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// word_frame_deframer_unit
// parses received 32-bit words against a start/type/id/body/end frame grammar
// ----------------------------------------------------------------------------
// path: input register, then combinational parser, then result register
// one item per cycle if not stalled; a stalled result blocks at most the input reg
// each item yields exactly one result item
// reset: synchronous active low, clears config, phase and both valid flags
// config writes apply at the next edge; user writes only while idle, unenforced
module word_frame_deframer_unit #(
    parameter int unsigned MAX_PAYLOAD_BYTES = wfd_pkg::MaxPayloadBytesDflt
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [wfd_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [wfd_pkg::WordWidth-1:0]       i_cfg_data,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wfd_pkg::WordWidth-1:0]       i_rx_word,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_frame_status,
    output logic [wfd_pkg::WordWidth-1:0]       o_word_value,
    output logic                                o_state_id_write,
    output logic                                o_data_id_write,
    output logic                                o_state_value_write,
    output logic                                o_data_word_write,
    output logic [wfd_pkg::WordIndexWidth-1:0]  o_data_word_index,
    output logic                                o_state_frame_complete,
    output logic                                o_data_frame_complete,
    output logic [wfd_pkg::DataSizeWidth-1:0]   o_data_size
);
    import wfd_pkg::*;

`include "word_frame_deframer_unit_assert.svh"

    t_cfg                 cfg;
    t_result              parse_res;
    t_result              r_res;
    logic                 r_res_valid;
    logic                 r_in_valid;
    logic [WordWidth-1:0] r_in_word;
    logic                 res_load;
    logic                 in_load;

    // config registers
    wfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register frees up when empty or when its item is taken
    assign res_load = !r_res_valid || !i_out_stall;
    // input register moves on when empty or when its word steps the parser
    assign in_load  = !r_in_valid || res_load;
    assign o_in_stall = !in_load;

    // input register: the received word as it arrived
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_word <= i_rx_word;
        end
    end

    // phase machine steps once per word that leaves the input register
    wfd_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && res_load),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (parse_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load && r_in_valid) begin
            r_res <= parse_res;
        end
    end

    assign o_out_valid            = r_res_valid;
    assign o_frame_status         = r_res.frame_status;
    assign o_word_value           = r_res.word_value;
    assign o_state_id_write       = r_res.state_id_write;
    assign o_data_id_write        = r_res.data_id_write;
    assign o_state_value_write    = r_res.state_value_write;
    assign o_data_word_write      = r_res.data_word_write;
    assign o_data_word_index      = r_res.data_word_index;
    assign o_state_frame_complete = r_res.state_frame_complete;
    assign o_data_frame_complete  = r_res.data_frame_complete;
    assign o_data_size            = r_res.data_size;

    // at most one write strobe per result
    `WFD_ASSERT_NOW(a_one_strobe, i_clk, i_rst_n, o_out_valid,
        $onehot0({o_state_id_write, o_data_id_write, o_state_value_write, o_data_word_write}))
    // any write strobe means the frame goes on
    `WFD_ASSERT_NOW(a_write_continues, i_clk, i_rst_n,
        o_out_valid && (o_state_id_write || o_data_id_write || o_state_value_write
                        || o_data_word_write), !o_frame_status)
    // completion only on a terminating word
    `WFD_ASSERT_NOW(a_complete_ends, i_clk, i_rst_n,
        o_out_valid && (o_state_frame_complete || o_data_frame_complete), o_frame_status)
    // a size is only reported with data completion
    `WFD_ASSERT_NOW(a_size_with_complete, i_clk, i_rst_n,
        o_out_valid && (o_data_size != '0), o_data_frame_complete)
    // a held input word reaches the result register next cycle when nothing stalls
    `WFD_ASSERT_NEXT(a_advance, i_clk, i_rst_n, r_in_valid && res_load, r_res_valid)

endmodule

FILE: bench/word_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// word_frame_deframer_checker
// follows the register writes and both item channels of the deframer, works
// out the result of every accepted word and compares it with what comes out
// ----------------------------------------------------------------------------
module word_frame_deframer_checker #(
    parameter int unsigned MAX_PAYLOAD_BYTES = wfd_pkg::MaxPayloadBytesDflt
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wfd_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [wfd_pkg::WordWidth-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [wfd_pkg::WordWidth-1:0]     i_rx_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  wfd_pkg::t_result                  i_result,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_pending,
    output int unsigned                       o_state_frames,
    output int unsigned                       o_data_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    import wfd_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_START,
        AWAIT_TYPE,
        STATE_ID,
        DATA_ID,
        STATE_WORD,
        DATA_LENGTH,
        STATE_CLOSE,
        PAYLOAD
    } t_phase;

    t_cfg        markers;
    t_phase      phase;
    int unsigned frame_words;
    int unsigned next_slot;
    t_result     predicted_results[$];

    function automatic int unsigned field_mismatch(string field, logic [31:0] want,
                                                   logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        logic [WordWidth-1:0] word;
        t_result              want;
        if (!i_rst_n) begin
            markers = '0;
            phase = AWAIT_START;
            frame_words = 0;
            next_slot = 0;
            predicted_results.delete();
            o_fail_count = 0;
            o_state_frames = 0;
            o_data_frames = 0;
        end else begin
            // results trail their word through both registers, so compare first
            if (i_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $error("result item with nothing predicted: word_value 0x%0h",
                           i_result.word_value);
                    o_fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    o_fail_count += field_mismatch("frame_status", want.frame_status,
                                                   i_result.frame_status)
                        + field_mismatch("word_value", want.word_value,
                                         i_result.word_value)
                        + field_mismatch("state_id_write", want.state_id_write,
                                         i_result.state_id_write)
                        + field_mismatch("data_id_write", want.data_id_write,
                                         i_result.data_id_write)
                        + field_mismatch("state_value_write", want.state_value_write,
                                         i_result.state_value_write)
                        + field_mismatch("data_word_write", want.data_word_write,
                                         i_result.data_word_write)
                        + field_mismatch("data_word_index", want.data_word_index,
                                         i_result.data_word_index)
                        + field_mismatch("state_frame_complete", want.state_frame_complete,
                                         i_result.state_frame_complete)
                        + field_mismatch("data_frame_complete", want.data_frame_complete,
                                         i_result.data_frame_complete)
                        + field_mismatch("data_size", want.data_size, i_result.data_size);
                    o_state_frames += want.state_frame_complete;
                    o_data_frames += want.data_frame_complete;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgStartMarker:     markers.start_marker = i_cfg_data;
                    CfgStateTypeMarker: markers.state_type_marker = i_cfg_data;
                    CfgDataTypeMarker:  markers.data_type_marker = i_cfg_data;
                    CfgEndMarker:       markers.end_marker = i_cfg_data;
                    CfgSwapBytes:       markers.swap_bytes = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                word = i_rx_word;
                if (markers.swap_bytes) begin
                    word = {word[7:0], word[15:8], word[23:16], word[31:24]};
                end
                want = '0;
                want.word_value = word;
                case (phase)
                    AWAIT_START: begin
                        if (word == markers.start_marker) phase = AWAIT_TYPE;
                        else want.frame_status = 1'b1;
                    end
                    AWAIT_TYPE: begin
                        // equal type markers resolve to a state frame
                        if (word == markers.state_type_marker) begin
                            phase = STATE_ID;
                        end else if (word == markers.data_type_marker) begin
                            phase = DATA_ID;
                        end else begin
                            phase = AWAIT_START;
                            want.frame_status = 1'b1;
                        end
                    end
                    STATE_ID: begin
                        want.state_id_write = 1'b1;
                        phase = STATE_WORD;
                    end
                    DATA_ID: begin
                        want.data_id_write = 1'b1;
                        phase = DATA_LENGTH;
                    end
                    STATE_WORD: begin
                        want.state_value_write = 1'b1;
                        phase = STATE_CLOSE;
                    end
                    STATE_CLOSE: begin
                        want.state_frame_complete = (word == markers.end_marker);
                        want.frame_status = 1'b1;
                        phase = AWAIT_START;
                    end
                    DATA_LENGTH: begin
                        if (word > MAX_PAYLOAD_BYTES) begin
                            want.frame_status = 1'b1;
                            phase = AWAIT_START;
                        end else begin
                            frame_words = word / BytesPerWord;
                            next_slot = 0;
                            phase = PAYLOAD;
                        end
                    end
                    default: begin
                        if (next_slot >= frame_words) begin
                            if (word == markers.end_marker) begin
                                want.data_frame_complete = 1'b1;
                                want.data_size = DataSizeWidth'(frame_words);
                            end
                            want.frame_status = 1'b1;
                            phase = AWAIT_START;
                        end else begin
                            want.data_word_write = 1'b1;
                            want.data_word_index = WordIndexWidth'(next_slot);
                            next_slot++;
                        end
                    end
                endcase
                predicted_results.push_back(want);
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

FILE: bench/word_frame_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// word_frame_deframer_unit_tb
// drives received words into the deframer under several marker settings, with
// and without byte swapping, and lets the checker compare every result item
// ----------------------------------------------------------------------------
module word_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfd_pkg::*;

    localparam int unsigned ClkPeriod    = 8;
    localparam int unsigned ResetCycles  = 5;
    localparam int unsigned TargetItems  = 1650;
    localparam int unsigned Segments     = 12;
    localparam int unsigned SettleCycles = 4;    // input and result registers plus margin
    localparam int unsigned QuietLimit   = 4000; // cycles with no handshake at all

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0]  cfg_index = '0;
    logic [WordWidth-1:0]      cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [WordWidth-1:0]      rx_word   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      frame_status;
    logic [WordWidth-1:0]      word_value;
    logic                      state_id_write;
    logic                      data_id_write;
    logic                      state_value_write;
    logic                      data_word_write;
    logic [WordIndexWidth-1:0] data_word_index;
    logic                      state_frame_complete;
    logic                      data_frame_complete;
    logic [DataSizeWidth-1:0]  data_size;
    t_result                   dut_result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned state_frames;
    int unsigned data_frames;

    // stimulus bookkeeping
    t_cfg        cur_cfg       = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;

    assign dut_result = {frame_status, word_value, state_id_write, data_id_write,
                         state_value_write, data_word_write, data_word_index,
                         state_frame_complete, data_frame_complete, data_size};

    word_frame_deframer_unit u_dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_rx_word              (rx_word),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_frame_status         (frame_status),
        .o_word_value           (word_value),
        .o_state_id_write       (state_id_write),
        .o_data_id_write        (data_id_write),
        .o_state_value_write    (state_value_write),
        .o_data_word_write      (data_word_write),
        .o_data_word_index      (data_word_index),
        .o_state_frame_complete (state_frame_complete),
        .o_data_frame_complete  (data_frame_complete),
        .o_data_size            (data_size)
    );

    word_frame_deframer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_rx_word      (rx_word),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result       (dut_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_state_frames (state_frames),
        .o_data_frames  (data_frames)
    );

    initial begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: give up once neither channel has moved an item for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word as the parser is to see it, with random gaps in front;
    // the wire carries it byte-reversed when swapping is on
    task automatic push_word(input logic [WordWidth-1:0] parsed);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_word <= cur_cfg.swap_bytes
                   ? {parsed[7:0], parsed[15:8], parsed[23:16], parsed[31:24]} : parsed;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // hold the sender off until every result is back, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [WordWidth-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // every register, plus two of the unused indexes, which must be ignored
    task automatic load_registers(input t_cfg c);
        logic [WordWidth-1:0] swap_word;
        swap_word = $urandom;
        swap_word[0] = c.swap_bytes;   // upper bits are don't-care
        cur_cfg = c;
        write_reg(CfgStartMarker, c.start_marker);
        write_reg(CfgStateTypeMarker, c.state_type_marker);
        write_reg(CfgDataTypeMarker, c.data_type_marker);
        write_reg(CfgEndMarker, c.end_marker);
        write_reg(CfgSwapBytes, swap_word);
        write_reg(CfgSwapBytes + 1'b1, $urandom);
        write_reg('1, $urandom);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // marker settings: random, all zero, all-ones extremes, shared type marker
    function automatic t_cfg pick_markers(input int unsigned seg);
        t_cfg c;
        c.start_marker = $urandom;
        c.state_type_marker = $urandom;
        c.data_type_marker = $urandom;
        c.end_marker = $urandom;
        case (seg % 4)
            0: begin
                if (c.data_type_marker == c.state_type_marker) begin
                    c.data_type_marker = ~c.state_type_marker;
                end
            end
            1: c = '0;
            2: begin
                c.start_marker = '1;
                c.state_type_marker = '0;
                c.data_type_marker = '1;
                c.end_marker = '1;
            end
            default: c.data_type_marker = c.state_type_marker;
        endcase
        c.swap_bytes = 1'((seg + seg / 4) % 2);
        return c;
    endfunction

    // mostly well-formed frames with random content; the rest is loose noise,
    // unknown type words and frames cut short
    task automatic send_sequence();
        logic [WordWidth-1:0] words[$];
        int unsigned          pick;
        int unsigned          len_bytes;
        int unsigned          keep;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 3)) words.push_back($urandom);
        end else if (pick < 13) begin
            words.push_back(cur_cfg.start_marker);
            words.push_back($urandom);
        end else begin
            words.push_back(cur_cfg.start_marker);
            if ($urandom_range(1)) begin
                words.push_back(cur_cfg.state_type_marker);
                words.push_back($urandom);   // id
                words.push_back($urandom);   // state word
                words.push_back($urandom_range(99) < 85 ? cur_cfg.end_marker : $urandom);
            end else begin
                words.push_back(cur_cfg.data_type_marker);
                words.push_back($urandom);   // id
                if ($urandom_range(99) < 12) begin
                    // oversize length, parser drops back to waiting
                    len_bytes = $urandom_range(1) ? $urandom_range(200, MaxPayloadBytesDflt + 1)
                                                  : $urandom;
                    words.push_back(len_bytes);
                end else begin
                    len_bytes = ($urandom_range(99) < 10) ? MaxPayloadBytesDflt
                                                          : $urandom_range(MaxPayloadBytesDflt);
                    words.push_back(len_bytes);
                    repeat (len_bytes / BytesPerWord) words.push_back($urandom);
                    words.push_back($urandom_range(99) < 85 ? cur_cfg.end_marker : $urandom);
                end
            end
            // broken frame: stop somewhere before the end
            if (pick >= 92 && words.size() > 1) begin
                keep = $urandom_range(1, words.size() - 1);
                while (words.size() > keep) void'(words.pop_back());
            end
        end
        foreach (words[i]) push_word(words[i]);
    endtask

    initial begin
        t_cfg                 directed_cfg;
        logic [WordWidth-1:0] directed[$];
        int unsigned          seg_items;
        int unsigned          seg_start;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first idling phase: sender seldom idle, receiver mostly stalled
        send_idle_pct = 19;
        recv_idle_pct = 86;

        // directed part under distinct markers, no byte swap
        directed_cfg.start_marker      = 32'hA5A5_5A5A;
        directed_cfg.state_type_marker = 32'h0000_0053;
        directed_cfg.data_type_marker  = 32'h0000_0044;
        directed_cfg.end_marker        = 32'h5A5A_A5A5;
        directed_cfg.swap_bytes        = 1'b0;
        load_registers(directed_cfg);
        directed = '{
            // stray words while waiting for a start marker
            32'h0000_0000, 32'hFFFF_FFFF,
            // start followed by an unknown type word
            directed_cfg.start_marker, 32'h1234_5678,
            // state frame closed properly
            directed_cfg.start_marker, directed_cfg.state_type_marker,
            32'hFFFF_FFFF, 32'h0000_0000, directed_cfg.end_marker,
            // data frame with zero length, closed properly
            directed_cfg.start_marker, directed_cfg.data_type_marker,
            32'h0000_0000, 32'd0, directed_cfg.end_marker,
            // seven bytes truncate to one word, closed by a wrong end word
            directed_cfg.start_marker, directed_cfg.data_type_marker,
            32'h0000_0001, 32'd7, 32'hFFFF_FFFF, 32'h0000_0000,
            // one byte over the maximum length
            directed_cfg.start_marker, directed_cfg.data_type_marker,
            32'h8000_0000, MaxPayloadBytesDflt + 1
        };
        foreach (directed[i]) push_word(directed[i]);

        // random part: four marker settings in each of the three idling phases
        seg_items = (TargetItems - items_sent) / Segments;
        for (int unsigned seg = 0; seg < Segments; seg++) begin
            if (seg == Segments / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 19;
            end else if (seg == 2 * Segments / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            load_registers(pick_markers(seg));
            seg_start = items_sent;
            while (items_sent - seg_start < seg_items) begin
                send_sequence();
                // now and then let the result side drain completely
                if ($urandom_range(39) == 0) wait_idle();
            end
        end

        wait_idle();
        $display("run: %0d words under %0d marker settings, with and without byte swap",
                 items_sent, settings_used);
        $display("run: %0d state frames and %0d data frames closed by an end marker",
                 state_frames, data_frames);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: word_frame_deframer_unit.f
+incdir+hw/rtl
hw/rtl/wfd_pkg.sv
hw/rtl/wfd_cfg_regs.sv
hw/rtl/wfd_parser.sv
hw/rtl/word_frame_deframer_unit.sv
bench/word_frame_deframer_checker.sv
bench/word_frame_deframer_unit_tb.sv
